[hdl/fba_pkg.sv]
// shared types, constants and search helpers for the frame bitmap allocator
package fba_pkg;

   localparam int MAX_FRAMES = 4096;
   localparam int WORD_W     = 32;
   localparam int WORDS      = MAX_FRAMES / WORD_W;
   localparam int WIDX_W     = $clog2(WORDS);
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int FRAME_W    = 12;
   localparam int CNT_W      = 13;
   localparam int LIMIT_W    = CNT_W - BIT_W;
   localparam int GROUP_W    = 8;
   localparam int LANE_W     = $clog2(GROUP_W);
   localparam int GROUPS     = WORDS / GROUP_W;
   localparam int GIDX_W     = $clog2(GROUPS);
   localparam int QDEPTH     = 2;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = CNT_W'(MAX_FRAMES);

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_TEST  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ECHO  = 2'd0,
      KIND_ALLOC = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_TEST  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [FRAME_W-1:0] entry_frame;
      logic               for_kernel;
      logic               want_writable;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] new_frame;
      logic               present;
      logic               writable;
      logic               user_mode;
      logic               out_of_frames;
      logic               frame_in_use;
   } rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic [FRAME_W-1:0] frame;
      logic               writable;
      logic               user_mode;
   } cmd_type;

   // lowest set bit of the group summary
   function automatic logic [GIDX_W-1:0] first_group(input logic [GROUPS-1:0] v);
      logic [GIDX_W-1:0] r;
      r = '0;
      for (int i = GROUPS - 1; i >= 0; i--) begin
         if (v[i]) r = GIDX_W'(i);
      end
      return r;
   endfunction

   // lowest set bit within one group of words
   function automatic logic [LANE_W-1:0] first_lane(input logic [GROUP_W-1:0] v);
      logic [LANE_W-1:0] r;
      r = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (v[i]) r = LANE_W'(i);
      end
      return r;
   endfunction

   // lowest clear bit of a bitmap word
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

endpackage

[hdl/fba_front.sv]
// front end: classifies request beats and holds them in a short command queue
module fba_front
   import fba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    head_pop
);

   cmd_type            cmd_w;
   cmd_type            q_ff [QDEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;

   // classify
   always_comb begin
      cmd_w.frame     = req_data.entry_frame;
      cmd_w.writable  = req_data.want_writable;
      cmd_w.user_mode = ~req_data.for_kernel;
      unique case (req_data.mode)
         MODE_ALLOC: cmd_w.kind = (req_data.entry_frame == '0) ? KIND_ALLOC : KIND_ECHO;
         MODE_FREE:  cmd_w.kind = (req_data.entry_frame == '0) ? KIND_ECHO : KIND_FREE;
         MODE_TEST:  cmd_w.kind = KIND_TEST;
         default:    cmd_w.kind = KIND_ECHO;
      endcase
   end

   assign req_stall  = (count_ff == QCNT_W'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head_cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) count_in = count_ff + QCNT_W'(1);
      else if (!push && head_pop) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cmd_w;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("command queue over capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> count_ff != '0)
      else $error("pop from empty command queue");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop && count_ff == QCNT_W'(1)) |=> req_stall)
      else $error("queue full but request not stalled");

endmodule

[hdl/fba_back.sv]
// back end: bitmap memory, full-word summary and the allocate/free/test sequencer
module fba_back
   import fba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] frame_count,
   input  logic             head_valid,
   input  cmd_type          head_cmd,
   output logic             head_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_PICK  = 4'b0100,
      ST_APPLY = 4'b1000
   } state_type;

   localparam logic [LIMIT_W-1:0] WORDS_LIM = LIMIT_W'(WORDS);

   logic [WORD_W-1:0]  mem [WORDS];
   logic [WORDS-1:0]   valid_ff;
   logic [WORDS-1:0]   full_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [WIDX_W-1:0]  word_ff, word_in;
   logic [GROUPS-1:0]  group_free_ff, group_free_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic [LIMIT_W-1:0] limit_w;
   logic [WORDS-1:0]   avail;
   logic [GROUPS-1:0]  group_any;
   logic [GIDX_W-1:0]  gsel;
   logic [LANE_W-1:0]  lane;
   logic [WORD_W-1:0]  cur_word;
   logic [BIT_W-1:0]   bit_sel;
   logic [WORD_W-1:0]  bit_mask;
   logic               out_free;
   logic               rd_en;
   logic [WIDX_W-1:0]  rd_addr;
   logic               wr_en;
   logic [WORD_W-1:0]  wr_data;
   logic               result_load;
   rsp_type            result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // searched words saturate at the bitmap size
   assign limit_w = (frame_count[CNT_W-1:BIT_W] > WORDS_LIM) ? WORDS_LIM
                                                             : frame_count[CNT_W-1:BIT_W];

   always_comb begin
      for (int w = 0; w < WORDS; w++) begin
         avail[w] = !full_ff[w] && (LIMIT_W'(w) < limit_w);
      end
      for (int g = 0; g < GROUPS; g++) begin
         group_any[g] = |avail[g*GROUP_W +: GROUP_W];
      end
   end

   assign gsel     = first_group(group_free_ff);
   assign lane     = first_lane(avail[{gsel, LANE_W'(0)} +: GROUP_W]);
   assign cur_word = rd_valid_ff ? rd_data_ff : '0;
   assign bit_sel  = (cmd_ff.kind == KIND_ALLOC) ? first_zero(cur_word)
                                                 : cmd_ff.frame[BIT_W-1:0];
   assign bit_mask = WORD_W'(1) << bit_sel;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      group_free_in = group_free_ff;
      head_pop      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_data       = cur_word;
      result_load   = 1'b0;
      result        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_cmd.kind)
                  KIND_ECHO: begin
                     if (out_free) begin
                        head_pop         = 1'b1;
                        result_load      = 1'b1;
                        result.new_frame = head_cmd.frame;
                     end
                  end
                  KIND_ALLOC: begin
                     head_pop = 1'b1;
                     cmd_in   = head_cmd;
                     state_in = ST_SCAN;
                  end
                  KIND_FREE, KIND_TEST: begin
                     head_pop = 1'b1;
                     cmd_in   = head_cmd;
                     rd_en    = 1'b1;
                     rd_addr  = head_cmd.frame[FRAME_W-1:BIT_W];
                     word_in  = head_cmd.frame[FRAME_W-1:BIT_W];
                     state_in = ST_APPLY;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            group_free_in = group_any;
            state_in      = ST_PICK;
         end
         ST_PICK: begin
            if (|group_free_ff) begin
               rd_en    = 1'b1;
               rd_addr  = {gsel, lane};
               word_in  = {gsel, lane};
               state_in = ST_APPLY;
            end else if (out_free) begin
               result_load          = 1'b1;
               result.out_of_frames = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               result_load = 1'b1;
               state_in    = ST_IDLE;
               unique case (cmd_ff.kind)
                  KIND_ALLOC: begin
                     wr_en            = 1'b1;
                     wr_data          = cur_word | bit_mask;
                     result.new_frame = {word_ff, bit_sel};
                     result.present   = 1'b1;
                     result.writable  = cmd_ff.writable;
                     result.user_mode = cmd_ff.user_mode;
                  end
                  KIND_FREE: begin
                     wr_en   = 1'b1;
                     wr_data = cur_word & ~bit_mask;
                  end
                  KIND_TEST: begin
                     // the entry keeps its frame, only the bit is reported
                     result.new_frame    = cmd_ff.frame;
                     result.frame_in_use = cur_word[bit_sel];
                  end
                  default: begin
                     result.new_frame = cmd_ff.frame;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = result_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[word_ff] <= 1'b1;
            full_ff[word_ff]  <= &wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      word_ff       <= word_in;
      group_free_ff <= group_free_in;
      if (result_load) rsp_data_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[word_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   a_full_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (full_ff & ~valid_ff) == '0)
      else $error("summary marks an unwritten word full");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      result_load |-> out_free)
      else $error("result loaded over a waiting beat");

   a_alloc_present: assert property (@(posedge clock) disable iff (reset)
      (wr_en && cmd_ff.kind == KIND_ALLOC) |=> (rsp_valid_ff && rsp_data_ff.present))
      else $error("allocation write without present result");

endmodule

[hdl/frame_bitmap_allocator.sv]
// top level of the first-fit page frame allocator over a frame bitmap
// pass-through requests go from the command queue straight to the result register; free
// and test read the bitmap word, after which free clears its bit; allocate runs summary
// scan, word pick, read, update; the sequencer takes a new request only when idle, and a
// 2-beat queue decouples intake from execution
// synchronous reset clears every bitmap word at once through per-word valid bits,
// with no clearing pass, and sets frame_count to 4096
module frame_bitmap_allocator
   import fba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   // number of frames managed, only whole words are searched
   logic [CNT_W-1:0] frame_count_ff, frame_count_in;

   // front to back command handoff
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   assign frame_count_in = csr_wr_en ? csr_wr_data : frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   // intake: classify each beat and queue it
   fba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   // execution: bitmap search and update, result register
   fba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_count (frame_count_ff),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[tb/tb.sv]
// self-checking testbench for the first-fit frame bitmap allocator
module tb;
   import fba_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no beat on either channel
   localparam int SETTLE      = 8;      // allocate is the slowest path
   localparam int PRINT_CAP   = 100;    // keep a broken run readable

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   frame_bitmap_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the allocator state
   logic [WORD_W-1:0] frame_map [WORDS];
   int                frame_limit = MAX_FRAMES;

   // requests waiting for the driver, page entry updates waiting for the monitor
   req_type request_backlog [$];
   rsp_type entry_updates   [$];

   int  mismatch_count = 0;
   int  beats_in       = 0;
   int  beats_out      = 0;
   int  settings_seen  = 1;
   int  alloc_hits     = 0;
   int  alloc_misses   = 0;
   int  frees_done     = 0;
   int  tests_done     = 0;
   int  idle_pct       = 20;   // chance in percent of starting a gap or a stall burst
   bit  quiet          = 1'b0; // no gaps and no stalls in the tail of the run
   int  send_gap       = 0;
   int  stall_left     = 0;
   int  idle_cycles    = 0;

   // apply one request to the shadow bitmap and return the new page entry
   function automatic rsp_type apply_to_frame_map(input req_type r);
      rsp_type o;
      int      words;
      int      w;
      int      b;
      bit      found;
      o           = '0;
      o.new_frame = r.entry_frame;
      found       = 1'b0;
      case (r.mode)
         MODE_ALLOC: begin
            // an entry that already holds a frame is left alone
            if (r.entry_frame == '0) begin
               // only whole words are searched, capped at the bitmap size
               words = frame_limit / WORD_W;
               if (words > WORDS) words = WORDS;
               for (w = 0; w < words && !found; w++) begin
                  if (frame_map[w] != '1) begin
                     for (b = 0; b < WORD_W && !found; b++) begin
                        if (!frame_map[w][b]) begin
                           frame_map[w][b] = 1'b1;
                           o.new_frame     = FRAME_W'(w * WORD_W + b);
                           o.present       = 1'b1;
                           o.writable      = r.want_writable;
                           o.user_mode     = !r.for_kernel;
                           found           = 1'b1;
                        end
                     end
                  end
               end
               if (found) begin
                  alloc_hits++;
               end else begin
                  o.new_frame     = '0;
                  o.out_of_frames = 1'b1;
                  alloc_misses++;
               end
            end
         end
         MODE_FREE: begin
            // frame zero in an entry means no frame, nothing to release
            if (r.entry_frame != '0 && (r.entry_frame / WORD_W) < WORDS)
               frame_map[r.entry_frame / WORD_W][r.entry_frame % WORD_W] = 1'b0;
            o.new_frame = '0;
            frees_done++;
         end
         MODE_TEST: begin
            if ((r.entry_frame / WORD_W) < WORDS)
               o.frame_in_use = frame_map[r.entry_frame / WORD_W][r.entry_frame % WORD_W];
            tests_done++;
         end
         default: begin
            // unused mode echoes the entry with every flag low
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at %0t on %s: got %0h want %0h", $realtime, what, got_v, want_v);
      mismatch_count++;
   endtask

   task automatic check_entry(input rsp_type got);
      rsp_type want;
      if (entry_updates.size() == 0) begin
         report_mismatch("result with no request pending", int'(got), 0);
         return;
      end
      want = entry_updates.pop_front();
      if (got.new_frame != want.new_frame)
         report_mismatch("new_frame", int'(got.new_frame), int'(want.new_frame));
      if (got.present != want.present)
         report_mismatch("present", int'(got.present), int'(want.present));
      if (got.writable != want.writable)
         report_mismatch("writable", int'(got.writable), int'(want.writable));
      if (got.user_mode != want.user_mode)
         report_mismatch("user_mode", int'(got.user_mode), int'(want.user_mode));
      if (got.out_of_frames != want.out_of_frames)
         report_mismatch("out_of_frames", int'(got.out_of_frames),
                         int'(want.out_of_frames));
      if (got.frame_in_use != want.frame_in_use)
         report_mismatch("frame_in_use", int'(got.frame_in_use),
                         int'(want.frame_in_use));
   endtask

   // request driver: a stalled beat holds, otherwise load the next one or sit out a gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  = 0;
      end else begin
         // beat taken at this edge, predict its entry update now
         if (req_valid && !req_stall) begin
            entry_updates.push_back(apply_to_frame_map(req_data));
            beats_in++;
         end
         if (req_valid && req_stall) begin
            // hold valid and payload while the block stalls
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            req_data  <= request_backlog.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < idle_pct)
               send_gap = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor with random stall bursts, with the stall always released between bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_entry(rsp_data);
            beats_out++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < idle_pct)
               stall_left = $urandom_range(1, 15);
         end
      end
   end

   // watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles, giving up", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_request(input mode_type m, input int frame, input bit kern,
                                input bit wr);
      req_type r;
      r.mode          = m;
      r.entry_frame   = FRAME_W'(frame);
      r.for_kernel    = kern;
      r.want_writable = wr;
      request_backlog.push_back(r);
   endtask

   // mostly well-formed traffic: allocate into empty entries, free and test hot frames
   task automatic queue_random(input int count, input int hot_span);
      req_type r;
      int      pick;
      repeat (count) begin
         r.entry_frame   = FRAME_W'($urandom_range(0, 4095));
         r.for_kernel    = 1'($urandom_range(0, 1));
         r.want_writable = 1'($urandom_range(0, 1));
         pick            = $urandom_range(0, 99);
         if (pick < 45) begin
            r.mode        = MODE_ALLOC;
            r.entry_frame = '0;
         end else if (pick < 50) begin
            // entry already populated
            r.mode = MODE_ALLOC;
            if (r.entry_frame == '0) r.entry_frame = FRAME_W'(1);
         end else if (pick < 75) begin
            r.mode        = MODE_FREE;
            r.entry_frame = FRAME_W'($urandom_range(0, hot_span));
         end else if (pick < 90) begin
            r.mode        = MODE_TEST;
            r.entry_frame = FRAME_W'($urandom_range(0, hot_span));
         end else if (pick < 95) begin
            r.mode = MODE_NONE;
         end else begin
            // noise over the whole field range
            r.mode = 2'($urandom_range(0, 3));
         end
         request_backlog.push_back(r);
      end
   endtask

   // wait for the block to go idle: nothing queued, nothing in flight
   task automatic drain_all();
      while (request_backlog.size() != 0 || req_valid || entry_updates.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_frame_count(input int value);
      drain_all();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      frame_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      idle_pct  = $urandom_range(0, 40);
      settings_seen++;
   endtask

   initial begin
      for (int i = 0; i < WORDS; i++) frame_map[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset frame count
      queue_request(MODE_TEST,  0,     1'b0, 1'b0);
      queue_request(MODE_ALLOC, 0,     1'b1, 1'b0);   // frame zero handed out
      queue_request(MODE_ALLOC, 0,     1'b0, 1'b1);
      queue_request(MODE_ALLOC, 0,     1'b1, 1'b1);
      queue_request(MODE_ALLOC, 5,     1'b0, 1'b1);   // entry already holds a frame
      queue_request(MODE_ALLOC, 4095,  1'b1, 1'b1);
      queue_request(MODE_TEST,  0,     1'b1, 1'b1);
      queue_request(MODE_TEST,  4095,  1'b0, 1'b0);
      queue_request(MODE_FREE,  0,     1'b1, 1'b1);   // free of no frame
      queue_request(MODE_TEST,  0,     1'b0, 1'b0);
      queue_request(MODE_FREE,  1,     1'b0, 1'b0);
      queue_request(MODE_TEST,  1,     1'b0, 1'b0);
      queue_request(MODE_ALLOC, 0,     1'b0, 1'b0);   // reuses the freed frame
      queue_request(MODE_FREE,  4095,  1'b1, 1'b0);
      queue_request(MODE_NONE,  'hABC, 1'b1, 1'b1);
      queue_request(MODE_NONE,  4095,  1'b0, 1'b0);
      queue_request(MODE_TEST,  2048,  1'b1, 1'b0);

      // under one word nothing is searched, every allocate fails
      write_frame_count(31);
      queue_request(MODE_ALLOC, 0, 1'b0, 1'b1);
      queue_request(MODE_TEST,  0, 1'b0, 1'b0);
      queue_request(MODE_FREE,  2, 1'b1, 1'b1);
      queue_request(MODE_ALLOC, 0, 1'b1, 1'b0);
      write_frame_count(0);
      queue_request(MODE_ALLOC, 0, 1'b1, 1'b1);
      queue_request(MODE_TEST,  2, 1'b0, 1'b0);

      // all ones, the search saturates at the bitmap size
      write_frame_count(8191);
      queue_random(350, 255);

      // one word only, exhausts quickly
      write_frame_count(32);
      queue_random(60, 40);

      write_frame_count(96);
      queue_random(300, 127);

      write_frame_count($urandom_range(32, 4096));
      queue_random(300, 255);

      // back to the reset value, tail of the run without any idling
      write_frame_count(MAX_FRAMES);
      queue_random(260, 255);
      while (request_backlog.size() != 0) @(negedge clock);
      quiet = 1'b1;
      queue_random(150, 255);

      drain_all();
      repeat (20) @(posedge clock);
      $display("covered %0d request beats, %0d result beats, %0d frame count settings",
               beats_in, beats_out, settings_seen);
      $display("allocations %0d, out of frames %0d, frees %0d, bit tests %0d",
               alloc_hits, alloc_misses, frees_done, tests_done);
      if (mismatch_count == 0 && entry_updates.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/fba_pkg.sv
hdl/fba_front.sv
hdl/fba_back.sv
hdl/frame_bitmap_allocator.sv
tb/tb.sv
